// ----- hw/rtl/ksort_pkg.sv -----
`default_nettype none

package ksort_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int ID_W          = 32;
	localparam int KEY_W         = 32;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIES       = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  item_id;
		logic [KEY_W-1:0] sort_key;
		logic             last;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0] item_id_res;
		logic            overflowed;
		logic            last_res;
	} out_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} ent_t;

	typedef struct packed {
		logic vld;
		ent_t dat;
	} rec_t;

	typedef struct packed {
		logic desc;
		logic ties;
	} order_t;

	// head of the chain, as seen by the sequencer
	typedef struct packed {
		logic vld;
		logic more;
	} head_t;

	// sequencer to chain
	typedef struct packed {
		logic   shift;
		logic   ovf;
		order_t ord;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FEED,
		ST_DRAIN,
		ST_EMIT
	} st_t;

	// true when a must come out ahead of b
	function automatic logic goes_before(ent_t a, ent_t b, order_t o);
		if (a.key != b.key) begin
			return o.desc ? (a.key > b.key) : (a.key < b.key);
		end
		if (o.desc && o.ties) begin
			return a.id > b.id;
		end
		return a.id < b.id;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/keyed_record_sorter_unit.sv -----
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | in_data  (item_id, sort_key, last)
// out     | output    | out_valid / out_stall | out_data (item_id_res, overflowed, last_res)
// cfg     | input     | cfg_we                | cfg_idx, cfg_wdata
//
// Loading takes one transaction per cycle into a record store. The last-marked
// transaction closes the list: the store is then streamed into the cell chain at
// one record per cycle, the chain is left to settle, and the sorted identifiers
// leave one per cycle from the head cell while out_stall is low. A list thus
// passes through the serial load, feed, settle and emit phases.
// Reset clears control state and restores the register defaults; stored records
// are not cleared. Input is stalled from the closing transaction until the final
// result has been taken; out_stall holds the whole cell chain in place.
module keyed_record_sorter_unit #(
	parameter int MAX_ITEMS = ksort_pkg::MAX_ITEMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ksort_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ksort_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  ksort_pkg::in_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output ksort_pkg::out_t                  out_data
);
	import ksort_pkg::*;

	// lane[i] feeds cell i; lane[MAX_ITEMS] is what would fall off the end
	rec_t  lane [MAX_ITEMS+1];
	rec_t  held [MAX_ITEMS];
	rec_t  right [MAX_ITEMS];
	head_t head;
	ctl_t  ctl;

	ksort_ctrl #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head),
		.feed      (lane[0]),
		.ctl       (ctl)
	);

	// Each cell keeps the best record it has seen and passes the loser right.
	// During emission the held records shift left by one per transaction.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right[i] = '0;
		end else begin : g_body
			assign right[i] = held[i+1];
		end

		ksort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ord        (ctl.ord),
			.shift      (ctl.shift),
			.lane_in    (lane[i]),
			.from_right (right[i]),
			.held       (held[i]),
			.pass       (lane[i+1])
		);
	end

	assign head.vld  = held[0].vld;
	assign head.more = held[1].vld;

	assign out_data = '{
		item_id_res: held[0].dat.id,
		overflowed:  ctl.ovf,
		last_res:    !held[1].vld
	};

	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!lane[MAX_ITEMS].vld)
		else $error("record pushed off the end of the chain");

endmodule

`default_nettype wire

// ----- hw/rtl/ksort_cell.sv -----
`default_nettype none

module ksort_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ksort_pkg::order_t ord,
	input  logic              shift,
	input  ksort_pkg::rec_t   lane_in,
	input  ksort_pkg::rec_t   from_right,
	output ksort_pkg::rec_t   held,
	output ksort_pkg::rec_t   pass
);
	import ksort_pkg::*;

	logic held_vld_q;
	logic pass_vld_q;
	ent_t held_dat_q;
	ent_t pass_dat_q;
	logic take_new;

	// keep the better of the incoming and held records, hand the other on
	assign take_new = !held_vld_q || goes_before(lane_in.dat, held_dat_q, ord);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (shift) begin
			held_vld_q <= from_right.vld;
			pass_vld_q <= 1'b0;
		end else if (lane_in.vld) begin
			held_vld_q <= 1'b1;
			pass_vld_q <= held_vld_q;
		end else begin
			pass_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_dat_q <= from_right.dat;
		end else if (lane_in.vld) begin
			if (take_new) begin
				held_dat_q <= lane_in.dat;
				pass_dat_q <= held_dat_q;
			end else begin
				pass_dat_q <= lane_in.dat;
			end
		end
	end

	assign held = '{vld: held_vld_q, dat: held_dat_q};
	assign pass = '{vld: pass_vld_q, dat: pass_dat_q};

endmodule

`default_nettype wire

// ----- hw/rtl/ksort_ctrl.sv -----
`default_nettype none

module ksort_ctrl #(
	parameter int MAX_ITEMS = ksort_pkg::MAX_ITEMS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ksort_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ksort_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ksort_pkg::in_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	input  ksort_pkg::head_t                     head,
	output ksort_pkg::rec_t                      feed,
	output ksort_pkg::ctl_t                      ctl
);
	import ksort_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

	st_t             state_q;
	st_t             state_d;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   rd_cnt_q;
	logic [CW:0]     drn_q;
	logic            ovf_q;
	order_t          cfg_q;
	order_t          ord_q;
	ent_t            mem [MAX_ITEMS];
	ent_t            feed_dat_s1;
	logic            feed_vld_s1;
	logic            in_acc;
	logic            out_acc;
	logic            out_last;
	logic            rd_en;
	logic            full;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign out_last = !head.more;
	assign full     = (fill_q == FULL);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && in_data.last) state_d = ST_FEED;
			end
			ST_FEED: begin
				if (rd_cnt_q + CW'(1) == fill_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drn_q == '0) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && out_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			ST_LOAD:  in_stall  = 1'b0;
			ST_FEED:  rd_en     = 1'b1;
			ST_DRAIN: ;
			ST_EMIT:  out_valid = head.vld;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			rd_cnt_q    <= '0;
			drn_q       <= '0;
			ovf_q       <= 1'b0;
			cfg_q       <= '{desc: 1'b0, ties: 1'b1};
			ord_q       <= '{desc: 1'b0, ties: 1'b1};
			feed_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			feed_vld_s1 <= rd_en;
			if (cfg_we) begin
				case (cfg_idx)
					REG_DESCENDING: cfg_q.desc <= cfg_wdata[0];
					REG_TIES:       cfg_q.ties <= cfg_wdata[0];
					default:        ;
				endcase
			end
			if (in_acc) begin
				if (full) ovf_q <= 1'b1;
				else      fill_q <= fill_q + CW'(1);
				if (in_data.last) ord_q <= cfg_q;
			end
			if (state_q == ST_LOAD) rd_cnt_q <= '0;
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
				// generous: covers read latency plus a full ripple down the chain
				drn_q    <= {1'b0, fill_q} + (CW+1)'(2);
			end
			if (state_q == ST_DRAIN) drn_q <= drn_q - (CW+1)'(1);
			if (out_acc && out_last) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	// record store
	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			mem[fill_q[AW-1:0]] <= '{id: in_data.item_id, key: in_data.sort_key};
		end
		if (rd_en) begin
			feed_dat_s1 <= mem[rd_cnt_q[AW-1:0]];
		end
	end

	assign feed      = '{vld: feed_vld_s1, dat: feed_dat_s1};
	assign ctl.shift = out_acc;
	assign ctl.ovf   = ovf_q;
	assign ctl.ord   = ord_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flagged with free entries");

	a_feed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEED) |-> (rd_cnt_q < fill_q))
		else $error("feed reads past stored records");

	a_list_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_last) |=> (state_q == ST_LOAD && fill_q == '0 && !ovf_q))
		else $error("list end did not return to loading");

endmodule

`default_nettype wire
